[sv/multi_token_bucket_limiter_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the token bucket limiter.
// Shared assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef MULTI_TOKEN_BUCKET_LIMITER_DEFINES_SVH
`define MULTI_TOKEN_BUCKET_LIMITER_DEFINES_SVH

// Checked only outside reset.
`define MTBL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MTBL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/mtbl_pkg.sv]
// ---------------------------------------------------------------------------
// Token bucket limiter package.
// Sizes, codes and shared types of the bucket table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtbl_pkg;

    localparam int NUM_BUCKETS = 64;
    localparam int TOKEN_BITS  = 16;

    localparam int KIND_W   = 2;
    localparam int HANDLE_W = 6;
    localparam int AMOUNT_W = 16;
    localparam int STATUS_W = 2;

    localparam int IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CNT_W = $clog2(NUM_BUCKETS + 1);
    localparam int CMP_W = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
    localparam int REQ_W = (TOKEN_BITS > AMOUNT_W) ? TOKEN_BITS : AMOUNT_W;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FETCH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [TOKEN_BITS-1:0] tokens;
        logic [TOKEN_BITS-1:0] rate;
        logic [TOKEN_BITS-1:0] limit;
    } t_entry;

    typedef struct packed {
        logic             refill;
        logic [REQ_W-1:0] amount;
        t_entry           entry;
    } t_upd_req;

    typedef struct packed {
        t_entry              entry;
        logic                wr;
        logic [STATUS_W-1:0] status;
        logic [AMOUNT_W-1:0] granted;
    } t_upd_rsp;

endpackage

[sv/mtbl_ifs.sv]
// ---------------------------------------------------------------------------
// Token bucket limiter channels.
// Request and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mtbl_in_if;
    logic                          valid;
    logic                          ready;
    logic [mtbl_pkg::KIND_W-1:0]   kind;
    logic [mtbl_pkg::HANDLE_W-1:0] handle;
    logic [mtbl_pkg::AMOUNT_W-1:0] amount;
    logic [mtbl_pkg::AMOUNT_W-1:0] rate;
    logic [mtbl_pkg::AMOUNT_W-1:0] burst;

    modport source (output valid, kind, handle, amount, rate, burst, input ready);
    modport sink   (input valid, kind, handle, amount, rate, burst, output ready);
endinterface

interface mtbl_out_if;
    logic                          valid;
    logic                          ready;
    logic [mtbl_pkg::STATUS_W-1:0] status;
    logic [mtbl_pkg::HANDLE_W-1:0] slot;
    logic [mtbl_pkg::AMOUNT_W-1:0] granted;

    modport source (output valid, status, slot, granted, input ready);
    modport sink   (input valid, status, slot, granted, output ready);
endinterface

[sv/multi_token_bucket_limiter.sv]
// ---------------------------------------------------------------------------
// Multi token bucket limiter.
// A table of token buckets held in one synchronous memory, with allocate,
// refill tick and fetch requests.
// ---------------------------------------------------------------------------
//  Channel   Direction  Word
//  i_in      in         kind, handle, amount, rate, burst
//  o_out     out        status, slot, granted
//
//  Allocate, invalid requests and a tick on an empty table are answered from idle.
//  A fetch does a memory read, then an update and write back.
//  A tick sweeps the N allocated buckets, one memory read a cycle.
//  A request is taken only when idle and the result register is free or
//  being emptied; a stalled result holds later requests back.
//  Reset is synchronous; the table needs no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_token_bucket_limiter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mtbl_in_if.sink           i_in,
    mtbl_out_if.source        o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SWEEP,
        S_RESP
    } t_state;

    t_state                          r_state;
    logic [mtbl_pkg::CNT_W-1:0]      r_count;
    logic [mtbl_pkg::CNT_W-1:0]      r_rd_ptr;
    logic [mtbl_pkg::IDX_W-1:0]      r_wr_idx;
    logic [mtbl_pkg::HANDLE_W-1:0]   r_handle;
    logic [mtbl_pkg::AMOUNT_W-1:0]   r_amount;
    logic                            r_out_valid;
    logic [mtbl_pkg::STATUS_W-1:0]   r_out_status;
    logic [mtbl_pkg::HANDLE_W-1:0]   r_out_slot;
    logic [mtbl_pkg::AMOUNT_W-1:0]   r_out_granted;
    logic [mtbl_pkg::STATUS_W-1:0]   r_res_status;
    logic [mtbl_pkg::AMOUNT_W-1:0]   r_res_granted;

    mtbl_pkg::t_entry                r_mem [mtbl_pkg::NUM_BUCKETS];
    mtbl_pkg::t_entry                r_rd_data;

    logic                            out_free;
    logic                            accept;
    logic                            full;
    logic                            fetch_ok;
    logic                            tick_go;
    logic                            sweep_last;
    logic                            mem_re;
    logic [mtbl_pkg::IDX_W-1:0]      mem_ra;
    logic                            mem_we;
    logic [mtbl_pkg::IDX_W-1:0]      mem_wa;
    mtbl_pkg::t_entry                mem_wd;
    logic [mtbl_pkg::STATUS_W-1:0]   imm_status;
    logic [mtbl_pkg::HANDLE_W-1:0]   imm_slot;
    mtbl_pkg::t_upd_req              upd_req;
    mtbl_pkg::t_upd_rsp              upd_rsp;

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in.valid && i_in.ready;

    assign o_out.valid   = r_out_valid;
    assign o_out.status  = r_out_status;
    assign o_out.slot    = r_out_slot;
    assign o_out.granted = r_out_granted;

    assign full     = (r_count == mtbl_pkg::CNT_W'(mtbl_pkg::NUM_BUCKETS));
    assign fetch_ok = (i_in.kind == mtbl_pkg::KIND_FETCH) && (i_in.amount != '0)
                      && (mtbl_pkg::CMP_W'(i_in.handle) < mtbl_pkg::CMP_W'(r_count));
    assign tick_go  = (i_in.kind == mtbl_pkg::KIND_TICK) && (r_count != '0);
    assign sweep_last = ((mtbl_pkg::CNT_W'(r_wr_idx) + mtbl_pkg::CNT_W'(1)) == r_count);

    assign upd_req.refill = (r_state == S_SWEEP);
    assign upd_req.amount = mtbl_pkg::REQ_W'(r_amount);
    assign upd_req.entry  = r_rd_data;

    mtbl_upd u_upd (
        .i_req (upd_req),
        .o_rsp (upd_rsp)
    );

    always_comb begin
        mem_re = 1'b0;
        mem_ra = '0;
        if (r_state == S_IDLE) begin
            if (accept && fetch_ok) begin
                mem_re = 1'b1;
                mem_ra = mtbl_pkg::IDX_W'(i_in.handle);
            end else if (accept && tick_go) begin
                mem_re = 1'b1;
            end
        end else if (r_state == S_SWEEP) begin
            mem_re = (r_rd_ptr < r_count);
            mem_ra = r_rd_ptr[mtbl_pkg::IDX_W-1:0];
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wr_idx;
        mem_wd = upd_rsp.entry;
        if (accept && (i_in.kind == mtbl_pkg::KIND_ALLOC) && !full) begin
            mem_we        = 1'b1;
            mem_wa        = r_count[mtbl_pkg::IDX_W-1:0];
            mem_wd.tokens = '0;
            mem_wd.rate   = mtbl_pkg::TOKEN_BITS'(mtbl_pkg::REQ_W'(i_in.rate));
            mem_wd.limit  = mtbl_pkg::TOKEN_BITS'(mtbl_pkg::REQ_W'(i_in.burst));
        end else if ((r_state == S_FETCH) || (r_state == S_SWEEP)) begin
            mem_we = upd_rsp.wr;
        end
    end

    always_comb begin
        imm_slot = i_in.handle;
        unique case (i_in.kind)
            mtbl_pkg::KIND_ALLOC: begin
                if (full) begin
                    imm_status = mtbl_pkg::ST_NOSPACE;
                end else begin
                    imm_status = mtbl_pkg::ST_OK;
                    imm_slot   = mtbl_pkg::HANDLE_W'(r_count);
                end
            end
            mtbl_pkg::KIND_TICK: imm_status = mtbl_pkg::ST_OK;
            default:             imm_status = mtbl_pkg::ST_INVALID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_ptr    <= '0;
            r_wr_idx    <= '0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_handle <= i_in.handle;
                        r_amount <= i_in.amount;
                        r_rd_ptr <= mtbl_pkg::CNT_W'(1);
                        r_wr_idx <= fetch_ok ? mtbl_pkg::IDX_W'(i_in.handle) : '0;
                        if (fetch_ok) begin
                            r_state <= S_FETCH;
                        end else if (tick_go) begin
                            r_state <= S_SWEEP;
                        end else begin
                            r_out_valid   <= 1'b1;
                            r_out_status  <= imm_status;
                            r_out_slot    <= imm_slot;
                            r_out_granted <= '0;
                            if ((i_in.kind == mtbl_pkg::KIND_ALLOC) && !full) begin
                                r_count <= r_count + mtbl_pkg::CNT_W'(1);
                            end
                        end
                    end
                end
                S_FETCH: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_status  <= upd_rsp.status;
                        r_out_slot    <= r_handle;
                        r_out_granted <= upd_rsp.granted;
                        r_state       <= S_IDLE;
                    end else begin
                        r_res_status  <= upd_rsp.status;
                        r_res_granted <= upd_rsp.granted;
                        r_state       <= S_RESP;
                    end
                end
                S_SWEEP: begin
                    if (r_rd_ptr < r_count) begin
                        r_rd_ptr <= r_rd_ptr + mtbl_pkg::CNT_W'(1);
                    end
                    r_wr_idx <= r_wr_idx + mtbl_pkg::IDX_W'(1);
                    if (sweep_last) begin
                        if (out_free) begin
                            r_out_valid   <= 1'b1;
                            r_out_status  <= mtbl_pkg::ST_OK;
                            r_out_slot    <= r_handle;
                            r_out_granted <= '0;
                            r_state       <= S_IDLE;
                        end else begin
                            r_res_status  <= mtbl_pkg::ST_OK;
                            r_res_granted <= '0;
                            r_state       <= S_RESP;
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_status  <= r_res_status;
                        r_out_slot    <= r_handle;
                        r_out_granted <= r_res_granted;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[sv/mtbl_upd.sv]
// ---------------------------------------------------------------------------
// Bucket update unit.
// Computes the refilled or debited bucket entry from the word read back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtbl_upd (
    input  mtbl_pkg::t_upd_req i_req,
    output mtbl_pkg::t_upd_rsp o_rsp
);

    logic [mtbl_pkg::TOKEN_BITS:0]   sum;
    logic [mtbl_pkg::REQ_W-1:0]      held;
    logic [mtbl_pkg::REQ_W-1:0]      take;

    always_comb begin
        sum  = {1'b0, i_req.entry.tokens} + {1'b0, i_req.entry.rate};
        held = mtbl_pkg::REQ_W'(i_req.entry.tokens);
        take = (i_req.amount < held) ? i_req.amount : held;

        o_rsp         = '0;
        o_rsp.entry   = i_req.entry;
        o_rsp.status  = mtbl_pkg::ST_OK;
        if (i_req.refill) begin
            o_rsp.wr = 1'b1;
            if (sum >= {1'b0, i_req.entry.limit}) begin
                o_rsp.entry.tokens = i_req.entry.limit;
            end else begin
                o_rsp.entry.tokens = sum[mtbl_pkg::TOKEN_BITS-1:0];
            end
        end else if (i_req.entry.tokens == '0) begin
            o_rsp.status = mtbl_pkg::ST_EMPTY;
        end else begin
            o_rsp.wr           = 1'b1;
            o_rsp.entry.tokens = i_req.entry.tokens - mtbl_pkg::TOKEN_BITS'(take);
            o_rsp.granted      = mtbl_pkg::AMOUNT_W'(take);
        end
    end

endmodule

[sv/mtbl_checker.sv]
// ---------------------------------------------------------------------------
// Token bucket limiter port checker.
// Watches the request and result channels of the limiter over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_token_bucket_limiter_defines.svh"

module mtbl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic [mtbl_pkg::KIND_W-1:0]   i_in_kind,
    input logic [mtbl_pkg::AMOUNT_W-1:0] i_in_amount,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [mtbl_pkg::STATUS_W-1:0] i_out_status,
    input logic [mtbl_pkg::HANDLE_W-1:0] i_out_slot,
    input logic [mtbl_pkg::AMOUNT_W-1:0] i_out_granted
);

    `MTBL_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !i_out_valid, "result valid after reset")

    `MTBL_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status) && $stable(i_out_slot) && $stable(i_out_granted), "stalled result word changed")

    `MTBL_ASSERT(a_zero_fetch, i_in_valid && i_in_ready && (i_in_kind == mtbl_pkg::KIND_FETCH) && (i_in_amount == '0) |=> i_out_valid && (i_out_status == mtbl_pkg::ST_INVALID) && (i_out_granted == '0), "zero fetch not rejected at once")

    `MTBL_ASSERT(a_rsvd_kind, i_in_valid && i_in_ready && (i_in_kind == mtbl_pkg::KIND_RSVD) |=> i_out_valid && (i_out_status == mtbl_pkg::ST_INVALID), "unknown request not rejected at once")

    `MTBL_ASSERT(a_grant_ok, i_out_valid && (i_out_granted != '0) |-> (i_out_status == mtbl_pkg::ST_OK), "tokens granted with a failing status")

endmodule

bind multi_token_bucket_limiter mtbl_checker u_mtbl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_kind     (i_in.kind),
    .i_in_amount   (i_in.amount),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_status  (o_out.status),
    .i_out_slot    (o_out.slot),
    .i_out_granted (o_out.granted)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the multi token bucket limiter.
// Words are sent in random bursts while the result side stalls on its own
// pattern. A ledger keeps a copy of the bucket table, works out the reply
// that each accepted request word must produce, and checks every result
// word against the oldest reply still due.
// ---------------------------------------------------------------------------

module tb_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_WORDS   = 1950;
    localparam int DRAIN_CYCLES   = mtbl_pkg::NUM_BUCKETS + 8;

    typedef struct {
        logic [mtbl_pkg::STATUS_W-1:0] status;
        logic [mtbl_pkg::HANDLE_W-1:0] slot;
        logic [mtbl_pkg::AMOUNT_W-1:0] granted;
    } t_reply;

    class bucket_ledger;
        logic [mtbl_pkg::TOKEN_BITS-1:0] tokens [mtbl_pkg::NUM_BUCKETS];
        logic [mtbl_pkg::TOKEN_BITS-1:0] rate   [mtbl_pkg::NUM_BUCKETS];
        logic [mtbl_pkg::TOKEN_BITS-1:0] limit  [mtbl_pkg::NUM_BUCKETS];
        bit                              live   [mtbl_pkg::NUM_BUCKETS];
        t_reply                          due [$];
        int                              failures;

        function new();
            for (int i = 0; i < mtbl_pkg::NUM_BUCKETS; i++) begin
                tokens[i] = '0;
                rate[i]   = '0;
                limit[i]  = '0;
                live[i]   = 1'b0;
            end
            failures = 0;
        endfunction

        function void note_request(logic [mtbl_pkg::KIND_W-1:0] kind,
                                   logic [mtbl_pkg::HANDLE_W-1:0] handle,
                                   logic [mtbl_pkg::AMOUNT_W-1:0] amount,
                                   logic [mtbl_pkg::AMOUNT_W-1:0] w_rate,
                                   logic [mtbl_pkg::AMOUNT_W-1:0] w_burst);
            t_reply                        r;
            bit                            found;
            logic [mtbl_pkg::TOKEN_BITS:0] sum;
            r.status  = mtbl_pkg::ST_INVALID;
            r.slot    = handle;
            r.granted = '0;
            found     = 1'b0;
            case (kind)
                mtbl_pkg::KIND_ALLOC: begin
                    r.status = mtbl_pkg::ST_NOSPACE;
                    for (int i = 0; i < mtbl_pkg::NUM_BUCKETS; i++) begin
                        if (!found && !live[i]) begin
                            found     = 1'b1;
                            live[i]   = 1'b1;
                            rate[i]   = w_rate[mtbl_pkg::TOKEN_BITS-1:0];
                            limit[i]  = w_burst[mtbl_pkg::TOKEN_BITS-1:0];
                            tokens[i] = '0;
                            r.status  = mtbl_pkg::ST_OK;
                            r.slot    = mtbl_pkg::HANDLE_W'(i);
                        end
                    end
                end
                mtbl_pkg::KIND_TICK: begin
                    for (int i = 0; i < mtbl_pkg::NUM_BUCKETS; i++) begin
                        if (live[i]) begin
                            sum = {1'b0, tokens[i]} + {1'b0, rate[i]};
                            if (sum >= {1'b0, limit[i]}) begin
                                sum = {1'b0, limit[i]};
                            end
                            tokens[i] = sum[mtbl_pkg::TOKEN_BITS-1:0];
                        end
                    end
                    r.status = mtbl_pkg::ST_OK;
                end
                mtbl_pkg::KIND_FETCH: begin
                    if (amount == '0 || !live[handle]) begin
                        r.status = mtbl_pkg::ST_INVALID;
                    end else if (tokens[handle] == '0) begin
                        r.status = mtbl_pkg::ST_EMPTY;
                    end else begin
                        r.granted = (amount < tokens[handle]) ? amount : tokens[handle];
                        tokens[handle] = tokens[handle] - r.granted;
                        r.status = mtbl_pkg::ST_OK;
                    end
                end
                default: begin
                end
            endcase
            due.push_back(r);
        endfunction

        function void check_reply(logic [mtbl_pkg::STATUS_W-1:0] status,
                                  logic [mtbl_pkg::HANDLE_W-1:0] slot,
                                  logic [mtbl_pkg::AMOUNT_W-1:0] granted);
            t_reply r;
            if (due.size() == 0) begin
                $display("%0t: unexpected result word status %0d slot %0d granted %0d",
                         $time, status, slot, granted);
                failures++;
            end else begin
                r = due.pop_front();
                if (status !== r.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, r.status, status);
                    failures++;
                end
                if (slot !== r.slot) begin
                    $display("%0t: slot expected %0d, got %0d", $time, r.slot, slot);
                    failures++;
                end
                if (granted !== r.granted) begin
                    $display("%0t: granted expected %0d, got %0d", $time, r.granted, granted);
                    failures++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mtbl_in_if  req_if ();
    mtbl_out_if rsp_if ();

    multi_token_bucket_limiter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    bucket_ledger ledger = new();
    int           quiet_cycles = 0;
    int           burst_left   = 0;
    int           allocs_sent  = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                ledger.note_request(req_if.kind, req_if.handle, req_if.amount,
                                    req_if.rate, req_if.burst);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                ledger.check_reply(rsp_if.status, rsp_if.slot, rsp_if.granted);
            end
        end
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The result side switches between free flow, random stalls and long stalls.
    initial begin
        int mode;
        int span;
        rsp_if.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(20, 200);
            for (int c = 0; c < span; c++) begin
                @(posedge i_clk);
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= ($urandom_range(0, 9) < 7);
                    default: rsp_if.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic logic [mtbl_pkg::AMOUNT_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return mtbl_pkg::AMOUNT_W'($urandom_range(0, 4));
            1: return mtbl_pkg::AMOUNT_W'($urandom_range(0, 255));
            2: return mtbl_pkg::AMOUNT_W'($urandom_range(0, 4000));
            3: return mtbl_pkg::AMOUNT_W'(16'hFFFF - $urandom_range(0, 15));
            default: return mtbl_pkg::AMOUNT_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic send_word(logic [mtbl_pkg::KIND_W-1:0] kind,
                             logic [mtbl_pkg::HANDLE_W-1:0] handle,
                             logic [mtbl_pkg::AMOUNT_W-1:0] amount,
                             logic [mtbl_pkg::AMOUNT_W-1:0] w_rate,
                             logic [mtbl_pkg::AMOUNT_W-1:0] w_burst);
        req_if.valid  <= 1'b1;
        req_if.kind   <= kind;
        req_if.handle <= handle;
        req_if.amount <= amount;
        req_if.rate   <= w_rate;
        req_if.burst  <= w_burst;
        if (kind == mtbl_pkg::KIND_ALLOC) begin
            allocs_sent++;
        end
        do @(posedge i_clk); while (!req_if.ready);
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_random_word();
        int                            pick;
        int                            live_count;
        logic [mtbl_pkg::HANDLE_W-1:0] handle;
        logic [mtbl_pkg::AMOUNT_W-1:0] amount;
        pick       = $urandom_range(0, 99);
        live_count = (allocs_sent > mtbl_pkg::NUM_BUCKETS) ? mtbl_pkg::NUM_BUCKETS
                                                           : allocs_sent;
        if (live_count > 0 && $urandom_range(0, 99) < 85) begin
            handle = mtbl_pkg::HANDLE_W'($urandom_range(0, live_count - 1));
        end else begin
            handle = mtbl_pkg::HANDLE_W'($urandom_range(0, 63));
        end
        amount = ($urandom_range(0, 9) == 0) ? '0 : pick_value();
        if (pick < 8) begin
            send_word(mtbl_pkg::KIND_ALLOC, handle, amount, pick_value(), pick_value());
        end else if (pick < 20) begin
            send_word(mtbl_pkg::KIND_TICK, handle, amount, pick_value(), pick_value());
        end else if (pick < 94) begin
            send_word(mtbl_pkg::KIND_FETCH, handle, amount, pick_value(), pick_value());
        end else begin
            send_word(mtbl_pkg::KIND_RSVD, handle, amount, pick_value(), pick_value());
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        req_if.valid  <= 1'b0;
        req_if.kind   <= mtbl_pkg::KIND_TICK;
        req_if.handle <= '0;
        req_if.amount <= '0;
        req_if.rate   <= '0;
        req_if.burst  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(mtbl_pkg::KIND_FETCH, 6'd0,  16'd5,    16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_TICK,  6'd0,  16'd0,    16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_RSVD,  6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(mtbl_pkg::KIND_ALLOC, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(mtbl_pkg::KIND_ALLOC, 6'd0,  16'd0,    16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_ALLOC, 6'd21, 16'h5555, 16'd3,    16'd10);
        send_word(mtbl_pkg::KIND_FETCH, 6'd0,  16'd1,    16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_FETCH, 6'd2,  16'd0,    16'hFFFF, 16'hFFFF);
        send_word(mtbl_pkg::KIND_TICK,  6'd42, 16'hAAAA, 16'hAAAA, 16'h5555);
        send_word(mtbl_pkg::KIND_FETCH, 6'd0,  16'hFFFF, 16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_TICK,  6'd0,  16'd0,    16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_TICK,  6'd0,  16'd0,    16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_FETCH, 6'd1,  16'd1,    16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_TICK,  6'd0,  16'd0,    16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_TICK,  6'd0,  16'd0,    16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_FETCH, 6'd2,  16'd4,    16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_FETCH, 6'd2,  16'hFFFF, 16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_FETCH, 6'd2,  16'd1,    16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_FETCH, 6'd63, 16'd1,    16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_ALLOC, 6'd0,  16'd0,    16'd100,  16'd7);
        send_word(mtbl_pkg::KIND_TICK,  6'd0,  16'd0,    16'd0,    16'd0);
        send_word(mtbl_pkg::KIND_FETCH, 6'd3,  16'd1,    16'd0,    16'd0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            send_random_word();
        end
        req_if.valid <= 1'b0;

        while (ledger.due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ledger.failures == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

[multi_token_bucket_limiter.f]
+incdir+sv
sv/mtbl_pkg.sv
sv/mtbl_ifs.sv
sv/mtbl_upd.sv
sv/multi_token_bucket_limiter.sv
sv/mtbl_checker.sv
tb/tb_top.sv
